// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mbiir6_pkg.sv =====
// ----------------------------------------------------------------------------
// mbiir6_pkg
// Widths, coefficient tables and state types of the band-pass IIR core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbiir6_pkg;

  localparam int ORDER    = 6;
  localparam int NUM_SETS = 6;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 32;
  localparam int HIST_W   = 48;
  localparam int COEF_W   = 32;
  localparam int OPND_W   = 33;
  localparam int ACC_W    = 64;
  localparam int BAND_W   = 3;
  localparam int TAP_W    = 3;

  // Highest valid band code; larger codes fall back to it.
  localparam logic [BAND_W-1:0] BAND_LAST = 3'd5;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Feed-forward taps b[0..6], Q6.26.
  localparam coef_t FF_COEF [NUM_SETS][ORDER+1] = '{
    '{32'sd2298820, 32'sd0, -32'sd6896460, 32'sd0, 32'sd6896460, 32'sd0, -32'sd2298820},
    '{32'sd661252,  32'sd0, -32'sd1983757, 32'sd0, 32'sd1983757, 32'sd0, -32'sd661252},
    '{32'sd98011,   32'sd0, -32'sd294033,  32'sd0, 32'sd294033,  32'sd0, -32'sd98011},
    '{32'sd2168995, 32'sd0, -32'sd6506985, 32'sd0, 32'sd6506985, 32'sd0, -32'sd2168995},
    '{32'sd597479,  32'sd0, -32'sd1792438, 32'sd0, 32'sd1792438, 32'sd0, -32'sd597479},
    '{32'sd78390,   32'sd0, -32'sd235171,  32'sd0, 32'sd235171,  32'sd0, -32'sd78390}
  };

  // Feedback taps a[0..6], Q6.26. Entry 0 is unity and is not used.
  localparam coef_t FB_COEF [NUM_SETS][ORDER+1] = '{
    '{32'sd67108864, -32'sd295229394, 32'sd541549450, -32'sd536674272,
      32'sd306626157, -32'sd95932028, 32'sd12551227},
    '{32'sd67108864, -32'sd336079020, 32'sd703449444, -32'sd789491270,
      32'sd502004027, -32'sd171589672, 32'sd24597628},
    '{32'sd67108864, -32'sd369549186, 32'sd849042649, -32'sd1041968735,
      32'sd720519879, -32'sd266211335, 32'sd41057865},
    '{32'sd67108864, -32'sd295209558, 32'sd543294426, -32'sd541830837,
      32'sd312187680, -32'sd98641794, 32'sd13091519},
    '{32'sd67108864, -32'sd336910377, 32'sd708221860, -32'sd799583310,
      32'sd512179747, -32'sd176591363, 32'sd25574666},
    '{32'sd67108864, -32'sd371175716, 32'sd857238189, -32'sd1058352661,
      32'sd736796994, -32'sd274262345, 32'sd42646689}
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_B0,
    S_MX,
    S_MH,
    S_ML,
    S_DRAIN,
    S_SUM,
    S_SAT,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACC_HI_ADD,
    ACC_HI_SUB,
    ACC_LO_SUB
  } acc_op_e;

endpackage

`default_nettype wire

// ===== design/multichannel_bandpass_iir6_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_bandpass_iir6_core
// Sixth-order direct-form-I band-pass IIR over several channels, one shared
// 32x33 multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_we_i                   cfg_wdata_i (band select)
//   in       in         in_valid_i / in_ready_o    channel_i, sample_i
//   out      out        out_valid_o / out_ready_i  out_channel_o, filtered_o,
//                                                  clipped_o
//
// Between one input transfer and the next, an item runs nineteen
// products through the single multiplier, one drain, then rounding,
// saturation and history write. An item for a channel outside the
// configured count skips these steps. The output register holds a result
// until it is taken, and a new input is accepted meanwhile; the sequencer
// waits in its last step only while that register is still full.
// Reset clears the band select, the per-channel fill counts and the
// output valid; the history memories need no clearing pass.
//
`default_nettype none
`include "assert_macros.svh"

module multichannel_bandpass_iir6_core #(
  parameter int CHANNELS = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic        [mbiir6_pkg::BAND_W-1:0]      cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic        [mbiir6_pkg::CHAN_W-1:0]      channel_i,
  input  logic signed [mbiir6_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic        [mbiir6_pkg::CHAN_W-1:0]      out_channel_o,
  output logic signed [mbiir6_pkg::OUT_W-1:0]       filtered_o,
  output logic                                      clipped_o
);

  import mbiir6_pkg::*;

  localparam int DEPTH = CHANNELS * ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Sequencer and configuration.
  state_e                  state_q, state_d;
  logic [BAND_W-1:0]       band_q;
  logic [BAND_W-1:0]       set_q;
  logic [TAP_W-1:0]        tap_q;
  logic                    bad_q;
  logic [TAP_W-1:0]        cnt_q [CHANNELS];
  logic [TAP_W-1:0]        wp_q  [CHANNELS];

  // Item registers.
  logic [CHAN_W-1:0]       ch_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [CH_W-1:0]         ch_idx;
  logic                    chan_ok;

  // History memories.
  logic signed [SAMPLE_W-1:0] xmem [DEPTH];
  logic [HIST_W-1:0]       ymem [DEPTH];
  logic signed [SAMPLE_W-1:0] xrd_q;
  logic [HIST_W-1:0]       yrd_q;
  logic                    rvalid_q;
  logic                    rd_en;
  logic [TAP_W-1:0]        rd_age;
  logic [TAP_W:0]          slot_sum;
  logic [TAP_W-1:0]        rd_slot;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic                    hist_we;

  // Multiplier and accumulators.
  logic                    mul_en;
  acc_op_e                 mul_op;
  coef_t                   coef;
  logic signed [OPND_W-1:0] opnd;
  logic signed [COEF_W+OPND_W-1:0] mul_full;
  logic [ACC_W-1:0]        prod_q;
  logic                    prod_vld_q;
  acc_op_e                 prod_op_q;
  logic [ACC_W-1:0]        hi_q;
  logic [ACC_W-1:0]        lo_q;
  logic [ACC_W-1:0]        s_q;

  // Rounding and saturation.
  logic [ACC_W-1:0]        s_rnd;
  logic [ACC_W-11:0]       y_wide;
  logic                    y_ovf;
  logic [HIST_W-1:0]       y_sat;
  logic [HIST_W-1:0]       y_q;
  logic                    clip_q;
  logic [HIST_W:0]         f_sum;
  logic [OUT_W:0]          f_wide;
  logic                    f_ovf;
  logic [OUT_W-1:0]        f_sat;

  // Output register.
  logic                    out_load;
  logic                    out_valid_q;
  logic [CHAN_W-1:0]       out_channel_q;
  logic [OUT_W-1:0]        filtered_q;
  logic                    clipped_q;

  assign chan_ok = (32'(channel_i) < CHANNELS);
  assign ch_idx  = CH_W'(ch_q);

  // The newest entry of a channel sits one slot below its write pointer.
  always_comb begin
    slot_sum = {1'b0, wp_q[ch_idx]} + (TAP_W+1)'(ORDER) - {1'b0, rd_age};
    if (slot_sum >= (TAP_W+1)'(ORDER)) begin
      rd_slot = TAP_W'(slot_sum - (TAP_W+1)'(ORDER));
    end else begin
      rd_slot = slot_sum[TAP_W-1:0];
    end
    rd_addr = AW'(int'(ch_idx) * ORDER + int'(rd_slot));
    wr_addr = AW'(int'(ch_idx) * ORDER + int'(wp_q[ch_idx]));
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_age     = tap_q + TAP_W'(1);
    mul_en     = 1'b0;
    mul_op     = ACC_HI_ADD;
    coef       = '0;
    opnd       = '0;
    hist_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = chan_ok ? S_B0 : S_FIN;
        end
      end
      S_B0: begin
        rd_en   = 1'b1;
        rd_age  = TAP_W'(1);
        mul_en  = 1'b1;
        coef    = FF_COEF[set_q][0];
        opnd    = OPND_W'(x_q);
        state_d = S_MX;
      end
      S_MX: begin
        mul_en  = 1'b1;
        coef    = FF_COEF[set_q][tap_q];
        opnd    = rvalid_q ? OPND_W'(xrd_q) : '0;
        state_d = S_MH;
      end
      S_MH: begin
        mul_en  = 1'b1;
        mul_op  = ACC_HI_SUB;
        coef    = FB_COEF[set_q][tap_q];
        opnd    = rvalid_q ? OPND_W'($signed(yrd_q[HIST_W-1:16])) : '0;
        state_d = S_ML;
      end
      S_ML: begin
        mul_en = 1'b1;
        mul_op = ACC_LO_SUB;
        coef   = FB_COEF[set_q][tap_q];
        opnd   = rvalid_q ? $signed({17'b0, yrd_q[15:0]}) : '0;
        if (tap_q == TAP_W'(ORDER)) begin
          state_d = S_DRAIN;
        end else begin
          // The current taps are already registered, so the next read can go.
          rd_en   = 1'b1;
          state_d = S_MX;
        end
      end
      S_DRAIN: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        hist_we = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mul_full = coef * opnd;

  // The low part carries past outputs' fraction bits at 2^-42; it joins the
  // high part with a floor shift by 16.
  assign s_rnd  = s_q + ACC_W'(512);
  assign y_wide = s_rnd[ACC_W-1:10];
  assign y_ovf  = (y_wide[ACC_W-11:HIST_W-1] != {(ACC_W-10-HIST_W+1){y_wide[ACC_W-11]}});
  assign y_sat  = y_ovf ? (y_wide[ACC_W-11] ? {1'b1, {(HIST_W-1){1'b0}}}
                                            : {1'b0, {(HIST_W-1){1'b1}}})
                        : y_wide[HIST_W-1:0];

  assign f_sum  = {y_q[HIST_W-1], y_q} + (HIST_W+1)'(32768);
  assign f_wide = f_sum[HIST_W:16];
  assign f_ovf  = (f_wide[OUT_W] != f_wide[OUT_W-1]);
  assign f_sat  = f_ovf ? (f_wide[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}})
                        : f_wide[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      band_q      <= '0;
      tap_q       <= '0;
      bad_q       <= 1'b0;
      rvalid_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_q[i] <= '0;
        wp_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      prod_vld_q <= mul_en;
      if (cfg_we_i) begin
        band_q <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        bad_q <= !chan_ok;
      end
      if (state_q == S_B0) begin
        tap_q <= TAP_W'(1);
      end else if (state_q == S_ML && rd_en) begin
        tap_q <= tap_q + TAP_W'(1);
      end
      if (rd_en) begin
        rvalid_q <= (rd_age <= cnt_q[ch_idx]);
      end
      if (hist_we) begin
        wp_q[ch_idx] <= (wp_q[ch_idx] == TAP_W'(ORDER - 1)) ? '0 : wp_q[ch_idx] + TAP_W'(1);
        if (cnt_q[ch_idx] != TAP_W'(ORDER)) begin
          cnt_q[ch_idx] <= cnt_q[ch_idx] + TAP_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q  <= channel_i;
      x_q   <= sample_i;
      set_q <= (band_q > BAND_LAST) ? BAND_LAST : band_q;
    end
    prod_q    <= mul_full[ACC_W-1:0];
    prod_op_q <= mul_op;
    if (state_q == S_IDLE) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (prod_vld_q) begin
      case (prod_op_q)
        ACC_HI_ADD: hi_q <= hi_q + prod_q;
        ACC_HI_SUB: hi_q <= hi_q - prod_q;
        ACC_LO_SUB: lo_q <= lo_q - prod_q;
        default: ;
      endcase
    end
    if (state_q == S_SUM) begin
      s_q <= hi_q + {{16{lo_q[ACC_W-1]}}, lo_q[ACC_W-1:16]};
    end
    if (state_q == S_SAT) begin
      y_q    <= y_sat;
      clip_q <= y_ovf;
    end
    if (out_load) begin
      out_channel_q <= ch_q;
      filtered_q    <= bad_q ? '0 : f_sat;
      clipped_q     <= !bad_q && (clip_q || f_ovf);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      xmem[wr_addr] <= x_q;
      ymem[wr_addr] <= y_sat;
    end
    if (rd_en) begin
      xrd_q <= xmem[rd_addr];
      yrd_q <= ymem[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign filtered_o    = filtered_q;
  assign clipped_o     = clipped_q;

  `ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_B0 || state_q == S_FIN)
  `ASSERT_IMPLIES(a_products_drained, clk_i, rst_ni, state_q == S_SUM, !prod_vld_q)
  `ASSERT_IMPLIES(a_ring_in_range, clk_i, rst_ni, state_q == S_SAT, wp_q[ch_idx] < TAP_W'(ORDER) && cnt_q[ch_idx] <= TAP_W'(ORDER))
  `ASSERT_NEXT(a_result_posted, clk_i, rst_ni, out_load, out_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire
